[hw/rtl/tls_client_hello_sni_extractor_macros.svh]
// Assertion macros used by the SNI extractor top module.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSNI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TSNI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tsni_pkg.sv]
// Types and constants of the TLS ClientHello SNI extractor.
`default_nettype none
package tsni_pkg;

	// Parser phases, one-hot.
	typedef enum logic [22:0] {
		PH_IDLE        = 23'b1 << 0,
		PH_DONE        = 23'b1 << 1,
		PH_REC_TYPE    = 23'b1 << 2,
		PH_REC_VER     = 23'b1 << 3,
		PH_REC_LEN     = 23'b1 << 4,
		PH_HS_TYPE     = 23'b1 << 5,
		PH_HS_LEN      = 23'b1 << 6,
		PH_SKIP_CV     = 23'b1 << 7,
		PH_SKIP_RANDOM = 23'b1 << 8,
		PH_SID_LEN     = 23'b1 << 9,
		PH_SKIP_SID    = 23'b1 << 10,
		PH_CS_LEN      = 23'b1 << 11,
		PH_SKIP_CS     = 23'b1 << 12,
		PH_CM_LEN      = 23'b1 << 13,
		PH_SKIP_CM     = 23'b1 << 14,
		PH_EXTS_LEN    = 23'b1 << 15,
		PH_EXT_TYPE    = 23'b1 << 16,
		PH_EXT_LEN     = 23'b1 << 17,
		PH_SKIP_EXT    = 23'b1 << 18,
		PH_SNI_LIST    = 23'b1 << 19,
		PH_SNI_TYPE    = 23'b1 << 20,
		PH_SNI_LEN     = 23'b1 << 21,
		PH_NAME        = 23'b1 << 22
	} phase_t;

	// One result word.
	typedef struct packed {
		logic [7:0] name_char;
		logic       char_valid;
		logic       verdict_done;
		logic       name_found;
	} result_t;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_VERSION_MIN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VERSION_MAX = 1'd1;

	localparam logic [15:0] VERSION_MIN_RST = 16'h0300;
	localparam logic [15:0] VERSION_MAX_RST = 16'h0304;

	localparam logic [7:0]  CT_HANDSHAKE     = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO  = 8'h01;
	localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;
	localparam logic [7:0]  NAME_TYPE_HOST   = 8'h00;
	localparam int unsigned RANDOM_BYTES     = 32;
	localparam int unsigned MIN_RECORD_BYTES = 9;
	localparam int unsigned SNI_EXT_MIN      = 5;
	localparam int unsigned SNI_LIST_MIN     = 3;

endpackage
`default_nettype wire

[hw/rtl/tsni_if.sv]
// Byte, result and configuration channel interfaces of the SNI extractor.
`default_nettype none
interface tsni_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_of_payload;
	logic        last_of_payload;
	logic [15:0] payload_length;

	modport source (output valid, data_byte, first_of_payload, last_of_payload,
		payload_length, input ready);
	modport sink (input valid, data_byte, first_of_payload, last_of_payload,
		payload_length, output ready);
endinterface

interface tsni_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_char;
	logic       char_valid;
	logic       verdict_done;
	logic       name_found;

	modport source (output valid, name_char, char_valid, verdict_done, name_found,
		input ready);
	modport sink (input valid, name_char, char_valid, verdict_done, name_found,
		output ready);
endinterface

interface tsni_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tsni_pkg::CFG_INDEX_W-1:0]  index;
	logic [15:0]                       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tls_client_hello_sni_extractor.sv]
// An accepted byte is held in the input register; its result word is registered in the result register.
// Throughput: one payload byte per cycle; a held result word stalls the input register.
// The whole per-byte parse step sits between the input register and the result register.
// Reset: parser idle until a first byte, stages empty, version window 0x0300..0x0304.
// Configuration writes are taken in any cycle.
`default_nettype none
`include "tls_client_hello_sni_extractor_macros.svh"
module tls_client_hello_sni_extractor #(
	parameter int unsigned LENGTH_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsni_byte_if.sink      byte_ch,
	tsni_result_if.source  result_ch,
	tsni_cfg_if.sink       cfg_ch
);
	logic        v_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        last_s1;
	logic [15:0] len_s1;
	logic        adv_s1;

	logic [15:0] version_min_q;
	logic [15:0] version_max_q;

	logic              res_valid;
	tsni_pkg::result_t res;
	logic              out_valid_q;
	tsni_pkg::result_t res_q;

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1 = v_s1 && (!out_valid_q || result_ch.ready);
	assign byte_ch.ready = !v_s1 || adv_s1;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_min_q <= tsni_pkg::VERSION_MIN_RST;
			version_max_q <= tsni_pkg::VERSION_MAX_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				tsni_pkg::REG_VERSION_MIN: version_min_q <= cfg_ch.data;
				tsni_pkg::REG_VERSION_MAX: version_max_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			v_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			data_s1 <= byte_ch.data_byte;
			first_s1 <= byte_ch.first_of_payload;
			last_s1 <= byte_ch.last_of_payload;
			len_s1 <= byte_ch.payload_length;
		end
	end

	tsni_parser #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (adv_s1),
		.data_byte        (data_s1),
		.first_of_payload (first_s1),
		.last_of_payload  (last_s1),
		.payload_length   (len_s1),
		.version_min      (version_min_q),
		.version_max      (version_max_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_valid;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.name_char = res_q.name_char;
	assign result_ch.char_valid = res_q.char_valid;
	assign result_ch.verdict_done = res_q.verdict_done;
	assign result_ch.name_found = res_q.name_found;

	`TSNI_ASSERT_NOW(a_word_nonempty, out_valid_q, res_q.char_valid || res_q.verdict_done, "empty result word")
	`TSNI_ASSERT_NOW(a_found_has_verdict, out_valid_q && res_q.name_found, res_q.verdict_done, "found without verdict")
	`TSNI_ASSERT_NEXT(a_s1_kept, v_s1 && !adv_s1, v_s1, "stage 1 byte dropped")
	`TSNI_ASSERT_NEXT(a_held_word, out_valid_q && !result_ch.ready, out_valid_q && $stable(res_q), "held result word lost")

endmodule
`default_nettype wire

[hw/rtl/tsni_parser.sv]
// Per-byte ClientHello parse state and next-state logic.
`default_nettype none
module tsni_parser #(
	parameter int unsigned LENGTH_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          data_byte,
	input  wire logic                first_of_payload,
	input  wire logic                last_of_payload,
	input  wire logic [15:0]         payload_length,
	input  wire logic [15:0]         version_min,
	input  wire logic [15:0]         version_max,
	output logic                     res_valid,
	output tsni_pkg::result_t        res
);
	localparam int unsigned LW = LENGTH_WIDTH;
	localparam int unsigned SW = LW + 1;
	// compare width: holds offset plus a 24-bit field without wrap
	localparam int unsigned CW = ((LW > 24) ? LW : 24) + 2;

	tsni_pkg::phase_t phase_q, ph, ph_nx;
	logic [LW-1:0] bp_q, bp, bp_nx;
	logic [LW-1:0] tl_q, tl;
	logic [23:0]   acc_q, acc, acc_in, acc_nx;
	logic [SW-1:0] skip_q, skip, skip_nx;
	logic [LW-1:0] ext_end_q, ext_end, ext_end_nx;
	logic [15:0]   ext_len_q, ext_len, ext_len_nx;
	logic          sni_q, sni, sni_nx;
	logic [15:0]   nrem_q, nrem, nrem_nx;

	logic [CW-1:0] off, len_w, acc_w, tgt;
	logic          endf, fin, found, ch;

	always_comb begin
		ph = phase_q;
		bp = bp_q;
		tl = tl_q;
		acc = acc_q;
		skip = skip_q;
		ext_end = ext_end_q;
		ext_len = ext_len_q;
		sni = sni_q;
		nrem = nrem_q;
		if (first_of_payload) begin
			ph = tsni_pkg::PH_REC_TYPE;
			bp = '0;
			tl = LW'(payload_length);
			acc = '0;
			skip = SW'(1);
			ext_end = '0;
			ext_len = '0;
			sni = 1'b0;
			nrem = '0;
		end

		off = CW'(bp) + CW'(1);
		acc_in = {acc[15:0], data_byte};
		len_w = CW'(tl);
		acc_w = CW'(acc_in);
		tgt = off + acc_w;
		endf = (off == CW'(skip));

		ph_nx = ph;
		bp_nx = bp;
		acc_nx = acc;
		skip_nx = skip;
		ext_end_nx = ext_end;
		ext_len_nx = ext_len;
		sni_nx = sni;
		nrem_nx = nrem;
		fin = 1'b0;
		found = 1'b0;
		ch = 1'b0;

		if (ph != tsni_pkg::PH_IDLE && ph != tsni_pkg::PH_DONE) begin
			bp_nx = off[LW-1:0];
			acc_nx = acc_in;
			case (ph)
				tsni_pkg::PH_REC_TYPE: begin
					if (len_w < CW'(tsni_pkg::MIN_RECORD_BYTES) ||
							acc_in != 24'(tsni_pkg::CT_HANDSHAKE)) begin
						fin = 1'b1;
					end else begin
						ph_nx = tsni_pkg::PH_REC_VER;
						skip_nx = SW'(off + CW'(2));
						acc_nx = '0;
					end
				end
				tsni_pkg::PH_REC_VER: begin
					if (endf) begin
						if (acc_w < CW'(version_min) || acc_w > CW'(version_max)) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_REC_LEN;
							skip_nx = SW'(off + CW'(2));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_REC_LEN: begin
					if (endf) begin
						if (acc_w + CW'(5) > len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_HS_TYPE;
							skip_nx = SW'(off + CW'(1));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_HS_TYPE: begin
					if (acc_in != 24'(tsni_pkg::HS_CLIENT_HELLO)) begin
						fin = 1'b1;
					end else begin
						ph_nx = tsni_pkg::PH_HS_LEN;
						skip_nx = SW'(off + CW'(3));
						acc_nx = '0;
					end
				end
				tsni_pkg::PH_HS_LEN: begin
					if (endf) begin
						if (tgt > len_w || off + CW'(2) > len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_SKIP_CV;
							skip_nx = SW'(off + CW'(2));
						end
					end
				end
				tsni_pkg::PH_SKIP_CV: begin
					if (endf) begin
						if (off + CW'(tsni_pkg::RANDOM_BYTES) > len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_SKIP_RANDOM;
							skip_nx = SW'(off + CW'(tsni_pkg::RANDOM_BYTES));
						end
					end
				end
				tsni_pkg::PH_SKIP_RANDOM: begin
					if (endf) begin
						if (off >= len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_SID_LEN;
							skip_nx = SW'(off + CW'(1));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_SID_LEN, tsni_pkg::PH_SKIP_SID: begin
					if (ph == tsni_pkg::PH_SID_LEN && tgt > len_w) begin
						fin = 1'b1;
					end else if (ph == tsni_pkg::PH_SID_LEN && acc_in != '0) begin
						ph_nx = tsni_pkg::PH_SKIP_SID;
						skip_nx = SW'(tgt);
					end else if (ph == tsni_pkg::PH_SID_LEN || endf) begin
						// session ID done: cipher suites length next
						if (off + CW'(2) > len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_CS_LEN;
							skip_nx = SW'(off + CW'(2));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_CS_LEN, tsni_pkg::PH_SKIP_CS: begin
					if (endf) begin
						if (ph == tsni_pkg::PH_CS_LEN && tgt > len_w) begin
							fin = 1'b1;
						end else if (ph == tsni_pkg::PH_CS_LEN && acc_in != '0) begin
							ph_nx = tsni_pkg::PH_SKIP_CS;
							skip_nx = SW'(tgt);
						end else if (off >= len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_CM_LEN;
							skip_nx = SW'(off + CW'(1));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_CM_LEN, tsni_pkg::PH_SKIP_CM: begin
					if (ph == tsni_pkg::PH_CM_LEN && tgt > len_w) begin
						fin = 1'b1;
					end else if (ph == tsni_pkg::PH_CM_LEN && acc_in != '0) begin
						ph_nx = tsni_pkg::PH_SKIP_CM;
						skip_nx = SW'(tgt);
					end else if (ph == tsni_pkg::PH_CM_LEN || endf) begin
						if (off + CW'(2) > len_w) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_EXTS_LEN;
							skip_nx = SW'(off + CW'(2));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_EXTS_LEN: begin
					if (endf) begin
						if (tgt > len_w) begin
							fin = 1'b1;
						end else begin
							ext_end_nx = tgt[LW-1:0];
							if (off + CW'(4) > tgt) begin
								fin = 1'b1;
							end else begin
								ph_nx = tsni_pkg::PH_EXT_TYPE;
								skip_nx = SW'(off + CW'(2));
								acc_nx = '0;
							end
						end
					end
				end
				tsni_pkg::PH_EXT_TYPE: begin
					if (endf) begin
						sni_nx = (acc_in[15:0] == tsni_pkg::EXT_SERVER_NAME);
						ph_nx = tsni_pkg::PH_EXT_LEN;
						skip_nx = SW'(off + CW'(2));
						acc_nx = '0;
					end
				end
				tsni_pkg::PH_EXT_LEN, tsni_pkg::PH_SKIP_EXT: begin
					if (endf) begin
						if (ph == tsni_pkg::PH_EXT_LEN) begin
							ext_len_nx = acc_in[15:0];
						end
						if (ph == tsni_pkg::PH_EXT_LEN && tgt > CW'(ext_end)) begin
							fin = 1'b1;
						end else if (ph == tsni_pkg::PH_EXT_LEN && sni) begin
							if (acc_w < CW'(tsni_pkg::SNI_EXT_MIN)) begin
								fin = 1'b1;
							end else begin
								ph_nx = tsni_pkg::PH_SNI_LIST;
								skip_nx = SW'(off + CW'(2));
								acc_nx = '0;
							end
						end else if (ph == tsni_pkg::PH_EXT_LEN && acc_in != '0) begin
							ph_nx = tsni_pkg::PH_SKIP_EXT;
							skip_nx = SW'(tgt);
						end else if (off + CW'(4) > CW'(ext_end)) begin
							// next extension header does not fit
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_EXT_TYPE;
							skip_nx = SW'(off + CW'(2));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_SNI_LIST: begin
					if (endf) begin
						if (acc_w < CW'(tsni_pkg::SNI_LIST_MIN)) begin
							fin = 1'b1;
						end else begin
							ph_nx = tsni_pkg::PH_SNI_TYPE;
							skip_nx = SW'(off + CW'(1));
							acc_nx = '0;
						end
					end
				end
				tsni_pkg::PH_SNI_TYPE: begin
					if (acc_in != 24'(tsni_pkg::NAME_TYPE_HOST)) begin
						fin = 1'b1;
					end else begin
						ph_nx = tsni_pkg::PH_SNI_LEN;
						skip_nx = SW'(off + CW'(2));
						acc_nx = '0;
					end
				end
				tsni_pkg::PH_SNI_LEN: begin
					if (endf) begin
						if (acc_w + CW'(tsni_pkg::SNI_EXT_MIN) > CW'(ext_len)) begin
							fin = 1'b1;
						end else if (acc_in == '0) begin
							fin = 1'b1;
							found = 1'b1;
						end else begin
							nrem_nx = acc_in[15:0];
							ph_nx = tsni_pkg::PH_NAME;
						end
					end
				end
				tsni_pkg::PH_NAME: begin
					ch = 1'b1;
					nrem_nx = nrem - 16'd1;
					if (nrem_nx == '0) begin
						fin = 1'b1;
						found = 1'b1;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
			// payload ran out before a verdict
			if (last_of_payload) begin
				fin = 1'b1;
			end
		end
		if (fin) begin
			ph_nx = tsni_pkg::PH_DONE;
		end

		res_valid = ch || fin;
		res.name_char = ch ? data_byte : 8'd0;
		res.char_valid = ch;
		res.verdict_done = fin;
		res.name_found = fin && found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsni_pkg::PH_IDLE;
			bp_q <= '0;
			tl_q <= '0;
			acc_q <= '0;
			skip_q <= '0;
			ext_end_q <= '0;
			ext_len_q <= '0;
			sni_q <= 1'b0;
			nrem_q <= '0;
		end else if (step) begin
			phase_q <= ph_nx;
			bp_q <= bp_nx;
			tl_q <= tl;
			acc_q <= acc_nx;
			skip_q <= skip_nx;
			ext_end_q <= ext_end_nx;
			ext_len_q <= ext_len_nx;
			sni_q <= sni_nx;
			nrem_q <= nrem_nx;
		end
	end

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking bench for the SNI extractor: directed byte table, then random payloads, mostly ClientHellos.
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned SEG_ITEMS    = 340;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] len;
	} byte_word_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_WORD} row_kind_t;

	typedef struct packed {
		byte_word_t        stim;
		row_kind_t         kind;
		tsni_pkg::result_t word;
	} dir_row_t;

	localparam tsni_pkg::result_t NO_WORD   = '{8'h00, 1'b0, 1'b0, 1'b0};
	localparam tsni_pkg::result_t NOT_FOUND = '{8'h00, 1'b0, 1'b1, 1'b0};

	dir_row_t dir_rows [25] = '{
		'{'{8'h16, 1'b0, 1'b0, 16'h0000}, ROW_SILENT,  NO_WORD},   // nothing started yet
		'{'{8'hFF, 1'b0, 1'b1, 16'hFFFF}, ROW_SILENT,  NO_WORD},
		'{'{8'h16, 1'b1, 1'b0, 16'd8},    ROW_WORD,    NOT_FOUND}, // too short for a record
		'{'{8'h01, 1'b0, 1'b1, 16'h0000}, ROW_SILENT,  NO_WORD},   // after the verdict
		'{'{8'h00, 1'b1, 1'b1, 16'h0000}, ROW_WORD,    NOT_FOUND},
		'{'{8'h16, 1'b1, 1'b0, 16'hFFFF}, ROW_PREDICT, NO_WORD},
		'{'{8'h03, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h04, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'hFF, 1'b0, 1'b0, 16'hAAAA}, ROW_PREDICT, NO_WORD},
		'{'{8'hFF, 1'b0, 1'b0, 16'h5555}, ROW_WORD,    NOT_FOUND}, // record length too big
		'{'{8'h16, 1'b1, 1'b0, 16'd100},  ROW_PREDICT, NO_WORD},
		'{'{8'h03, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h05, 1'b0, 1'b0, 16'h0000}, ROW_WORD,    NOT_FOUND}, // version above window
		'{'{8'h16, 1'b1, 1'b0, 16'd200},  ROW_PREDICT, NO_WORD},
		'{'{8'h02, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h16, 1'b1, 1'b0, 16'd9},    ROW_PREDICT, NO_WORD},   // restart mid-field
		'{'{8'h03, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h00, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h00, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h04, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h02, 1'b0, 1'b0, 16'h0000}, ROW_WORD,    NOT_FOUND}, // not a ClientHello
		'{'{8'h16, 1'b1, 1'b0, 16'd60},   ROW_PREDICT, NO_WORD},
		'{'{8'h03, 1'b0, 1'b0, 16'h0000}, ROW_PREDICT, NO_WORD},
		'{'{8'h03, 1'b0, 1'b1, 16'h0000}, ROW_WORD,    NOT_FOUND}, // payload ends early
		'{'{8'h55, 1'b0, 1'b0, 16'h0000}, ROW_SILENT,  NO_WORD}
	};

	logic [15:0] win_lo_set [6] = '{16'h0300, 16'h0000, 16'hFFFF, 16'h0303, 16'hFFFF, 16'h0000};
	logic [15:0] win_hi_set [6] = '{16'h0304, 16'hFFFF, 16'h0000, 16'h0303, 16'hFFFF, 16'h0000};

	logic clk = 1'b0;
	logic arst_n;

	tsni_byte_if   byte_ch();
	tsni_result_if result_ch();
	tsni_cfg_if    cfg_ch();

	tls_client_hello_sni_extractor #(.LENGTH_WIDTH(16)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tsni_pkg::result_t sni_words_due[$];
	logic [7:0]  frame[$];
	int unsigned items_sent;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;
	bit          hold_req;

	// parser copy
	tsni_pkg::phase_t ph;
	int unsigned pos, tot, acc, tgt, ext_end, ext_type, ext_len, name_left;
	bit          given;
	logic [15:0] win_lo, win_hi;

	function automatic void reset_parser();
		win_lo = tsni_pkg::VERSION_MIN_RST;
		win_hi = tsni_pkg::VERSION_MAX_RST;
		ph = tsni_pkg::PH_IDLE;
		pos = 0; tot = 0; acc = 0; tgt = 0;
		ext_end = 0; ext_type = 0; ext_len = 0; name_left = 0;
		given = 1'b0;
	endfunction

	function automatic void conclude();
		ph = tsni_pkg::PH_DONE;
		given = 1'b1;
	endfunction

	function automatic void open_field(tsni_pkg::phase_t p, int unsigned start,
			int unsigned width);
		ph = p;
		tgt = start + width;
		acc = 0;
	endfunction

	function automatic void open_skip(tsni_pkg::phase_t p, int unsigned target);
		ph = p;
		tgt = target;
	endfunction

	function automatic void after_session_id(int unsigned off);
		if (off + 2 > tot) conclude();
		else open_field(tsni_pkg::PH_CS_LEN, off, 2);
	endfunction

	function automatic void after_suites(int unsigned off);
		if (off >= tot) conclude();
		else open_field(tsni_pkg::PH_CM_LEN, off, 1);
	endfunction

	function automatic void after_compression(int unsigned off);
		if (off + 2 > tot) conclude();
		else open_field(tsni_pkg::PH_EXTS_LEN, off, 2);
	endfunction

	// next extension header must fit inside the extension block
	function automatic void next_extension(int unsigned off);
		if (off + 4 > ext_end) conclude();
		else open_field(tsni_pkg::PH_EXT_TYPE, off, 2);
	endfunction

	function automatic bit parse_byte(input byte_word_t w, output tsni_pkg::result_t word);
		int unsigned off, t;
		bit was_given, at_end, is_char, found;
		is_char = 1'b0;
		found = 1'b0;
		word = NO_WORD;
		if (w.first) begin
			tot = 32'(w.len);
			pos = 0; ext_end = 0; ext_type = 0; ext_len = 0; name_left = 0;
			given = 1'b0;
			open_field(tsni_pkg::PH_REC_TYPE, 0, 1);
		end
		if (ph == tsni_pkg::PH_IDLE) return 1'b0;
		was_given = given;
		if (ph != tsni_pkg::PH_DONE) begin
			off = pos + 1;
			acc = ((acc << 8) | 32'(w.data)) & 32'h00FF_FFFF;
			at_end = (off == tgt);
			case (ph)
			tsni_pkg::PH_REC_TYPE: begin
				if (tot < tsni_pkg::MIN_RECORD_BYTES || acc != tsni_pkg::CT_HANDSHAKE) conclude();
				else open_field(tsni_pkg::PH_REC_VER, off, 2);
			end
			tsni_pkg::PH_REC_VER: begin
				if (at_end) begin
					if (acc < win_lo || acc > win_hi) conclude();
					else open_field(tsni_pkg::PH_REC_LEN, off, 2);
				end
			end
			tsni_pkg::PH_REC_LEN: begin
				if (at_end) begin
					if (acc > tot - 5) conclude();
					else open_field(tsni_pkg::PH_HS_TYPE, off, 1);
				end
			end
			tsni_pkg::PH_HS_TYPE: begin
				if (acc != tsni_pkg::HS_CLIENT_HELLO) conclude();
				else open_field(tsni_pkg::PH_HS_LEN, off, 3);
			end
			tsni_pkg::PH_HS_LEN: begin
				if (at_end) begin
					if (off + acc > tot || off + 2 > tot) conclude();
					else open_skip(tsni_pkg::PH_SKIP_CV, off + 2);
				end
			end
			tsni_pkg::PH_SKIP_CV: begin
				if (at_end) begin
					if (off + tsni_pkg::RANDOM_BYTES > tot) conclude();
					else open_skip(tsni_pkg::PH_SKIP_RANDOM, off + tsni_pkg::RANDOM_BYTES);
				end
			end
			tsni_pkg::PH_SKIP_RANDOM: begin
				if (at_end) begin
					if (off >= tot) conclude();
					else open_field(tsni_pkg::PH_SID_LEN, off, 1);
				end
			end
			tsni_pkg::PH_SID_LEN: begin
				t = off + acc;
				if (t > tot) conclude();
				else if (acc == 0) after_session_id(off);
				else open_skip(tsni_pkg::PH_SKIP_SID, t);
			end
			tsni_pkg::PH_SKIP_SID: begin
				if (at_end) after_session_id(off);
			end
			tsni_pkg::PH_CS_LEN: begin
				if (at_end) begin
					t = off + acc;
					if (t > tot) conclude();
					else if (acc == 0) after_suites(off);
					else open_skip(tsni_pkg::PH_SKIP_CS, t);
				end
			end
			tsni_pkg::PH_SKIP_CS: begin
				if (at_end) after_suites(off);
			end
			tsni_pkg::PH_CM_LEN: begin
				t = off + acc;
				if (t > tot) conclude();
				else if (acc == 0) after_compression(off);
				else open_skip(tsni_pkg::PH_SKIP_CM, t);
			end
			tsni_pkg::PH_SKIP_CM: begin
				if (at_end) after_compression(off);
			end
			tsni_pkg::PH_EXTS_LEN: begin
				if (at_end) begin
					t = off + acc;
					if (t > tot) conclude();
					else begin
						ext_end = t;
						next_extension(off);
					end
				end
			end
			tsni_pkg::PH_EXT_TYPE: begin
				if (at_end) begin
					ext_type = acc;
					open_field(tsni_pkg::PH_EXT_LEN, off, 2);
				end
			end
			tsni_pkg::PH_EXT_LEN: begin
				if (at_end) begin
					ext_len = acc;
					if (off + acc > ext_end) conclude();
					else if (ext_type == tsni_pkg::EXT_SERVER_NAME) begin
						if (acc < tsni_pkg::SNI_EXT_MIN) conclude();
						else open_field(tsni_pkg::PH_SNI_LIST, off, 2);
					end else if (acc == 0) next_extension(off);
					else open_skip(tsni_pkg::PH_SKIP_EXT, off + acc);
				end
			end
			tsni_pkg::PH_SKIP_EXT: begin
				if (at_end) next_extension(off);
			end
			tsni_pkg::PH_SNI_LIST: begin
				if (at_end) begin
					if (acc < tsni_pkg::SNI_LIST_MIN) conclude();
					else open_field(tsni_pkg::PH_SNI_TYPE, off, 1);
				end
			end
			tsni_pkg::PH_SNI_TYPE: begin
				if (acc != tsni_pkg::NAME_TYPE_HOST) conclude();
				else open_field(tsni_pkg::PH_SNI_LEN, off, 2);
			end
			tsni_pkg::PH_SNI_LEN: begin
				if (at_end) begin
					if (acc > ext_len - tsni_pkg::SNI_EXT_MIN) conclude();
					else if (acc == 0) begin
						conclude();
						found = 1'b1;
					end else begin
						name_left = acc;
						ph = tsni_pkg::PH_NAME;
					end
				end
			end
			tsni_pkg::PH_NAME: begin
				is_char = 1'b1;
				name_left = (name_left - 1) & 32'hFFFF;
				if (name_left == 0) begin
					conclude();
					found = 1'b1;
				end
			end
			default: conclude();
			endcase
			pos = off & 32'hFFFF;
		end
		if (w.last && !given) conclude();
		if (!is_char && !(given && !was_given)) return 1'b0;
		word.name_char    = is_char ? w.data : 8'h00;
		word.char_valid   = is_char;
		word.verdict_done = given && !was_given;
		word.name_found   = given && !was_given && found;
		return 1'b1;
	endfunction

	function automatic void put16(ref logic [7:0] q[$], input int unsigned v);
		q.push_back(8'(v >> 8));
		q.push_back(8'(v));
	endfunction

	// well-formed ClientHello with random content into frame
	function automatic void build_hello();
		logic [7:0] body[$];
		logic [7:0] exts[$];
		int unsigned ver, n_other, sni_at, name_len, pad, n;
		frame.delete();
		if (win_lo <= win_hi && $urandom_range(9) != 0) ver = $urandom_range(win_hi, win_lo);
		else ver = $urandom_range(16'hFFFF);
		n_other = $urandom_range(3);
		sni_at = ($urandom_range(4) == 0) ? n_other + 1 : $urandom_range(n_other);
		for (int k = 0; k <= n_other; k++) begin
			if (k == sni_at) begin
				name_len = ($urandom_range(5) == 0) ? 0 : $urandom_range(12, 1);
				pad = ($urandom_range(3) == 0) ? $urandom_range(2) : 0;
				put16(exts, 32'(tsni_pkg::EXT_SERVER_NAME));
				put16(exts, tsni_pkg::SNI_EXT_MIN + name_len + pad);
				put16(exts, tsni_pkg::SNI_LIST_MIN + name_len);
				exts.push_back(tsni_pkg::NAME_TYPE_HOST);
				put16(exts, name_len);
				repeat (name_len + pad) exts.push_back(8'($urandom));
			end
			if (k < n_other) begin
				n = $urandom_range(6);
				put16(exts, $urandom_range(16'hFFFF, 1));
				put16(exts, n);
				repeat (n) exts.push_back(8'($urandom));
			end
		end
		put16(body, ver);
		repeat (tsni_pkg::RANDOM_BYTES) body.push_back(8'($urandom));
		n = $urandom_range(4);
		body.push_back(8'(n));
		repeat (n) body.push_back(8'($urandom));
		n = 2 * $urandom_range(3);
		put16(body, n);
		repeat (n) body.push_back(8'($urandom));
		n = $urandom_range(2);
		body.push_back(8'(n));
		repeat (n) body.push_back(8'($urandom));
		put16(body, exts.size());
		body = {body, exts};
		frame.push_back(tsni_pkg::CT_HANDSHAKE);
		put16(frame, ver);
		put16(frame, 4 + body.size());
		frame.push_back(tsni_pkg::HS_CLIENT_HELLO);
		frame.push_back(8'(body.size() >> 16));
		put16(frame, body.size());
		frame = {frame, body};
		if ($urandom_range(9) == 0) repeat ($urandom_range(4, 1)) frame.push_back(8'($urandom));
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic push_byte(input byte_word_t w, input row_kind_t kind,
			input tsni_pkg::result_t typed);
		tsni_pkg::result_t word;
		bit                has_word;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid            <= 1'b1;
		byte_ch.data_byte        <= w.data;
		byte_ch.first_of_payload <= w.first;
		byte_ch.last_of_payload  <= w.last;
		byte_ch.payload_length   <= w.len;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		has_word = parse_byte(w, word);
		if (kind == ROW_WORD) sni_words_due.push_back(typed);
		else if (kind == ROW_PREDICT && has_word) sni_words_due.push_back(word);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_payload();
		byte_word_t  w;
		logic [15:0] plen;
		bit          with_last;
		int unsigned n;
		with_last = 1'b1;
		if ($urandom_range(3) != 0) begin
			build_hello();
			plen = 16'(frame.size());
			case ($urandom_range(14))
			0: begin
				n = $urandom_range(frame.size() - 1);
				frame[n] = ($urandom_range(2) == 0) ? 8'h00 :
					($urandom_range(1) ? 8'hFF : 8'($urandom));
			end
			1: begin
				n = $urandom_range(frame.size() - 1, 1);
				frame = frame[0:n-1];
			end
			2: plen = 16'($urandom);
			3: plen = 16'($urandom_range(frame.size() + 3, frame.size() - 4));
			4: with_last = 1'b0;
			default: ;
			endcase
		end else begin
			frame.delete();
			repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom));
			if ($urandom_range(1)) frame[0] = tsni_pkg::CT_HANDSHAKE;
			plen = $urandom_range(1) ? 16'(frame.size()) : 16'($urandom);
		end
		foreach (frame[i]) begin
			w.data  = frame[i];
			w.first = (i == 0);
			w.last  = with_last && (i == frame.size() - 1);
			w.len   = (i == 0) ? plen : 16'($urandom);
			push_byte(w, ROW_PREDICT, NO_WORD);
		end
		// stray words with no start marker
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(3, 1)) begin
				w = '{8'($urandom), 1'b0, 1'b0, 16'($urandom)};
				push_byte(w, ROW_PREDICT, NO_WORD);
			end
		end
	endtask

	task automatic write_reg(input logic [tsni_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == tsni_pkg::REG_VERSION_MIN) win_lo = value;
		else if (idx == tsni_pkg::REG_VERSION_MAX) win_hi = value;
		@(negedge clk);
	endtask

	// drop valid, wait for every expected word, then let the pipe drain
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (sni_words_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		tsni_pkg::result_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.name_char    = result_ch.name_char;
			got.char_valid   = result_ch.char_valid;
			got.verdict_done = result_ch.verdict_done;
			got.name_found   = result_ch.name_found;
			if (sni_words_due.size() == 0) begin
				mismatches++;
				$display("%0t: expected no word, got %p", $time, got);
			end else begin
				want = sni_words_due.pop_front();
				check_field("name_char", want.name_char, got.name_char);
				check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
				check_field("verdict_done", 8'(want.verdict_done), 8'(got.verdict_done));
				check_field("name_found", 8'(want.name_found), 8'(got.name_found));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned seg_end;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.first_of_payload = 1'b0;
		byte_ch.last_of_payload = 1'b0;
		byte_ch.payload_length = 16'h0000;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = tsni_pkg::REG_VERSION_MIN;
		cfg_ch.data = 16'h0000;
		items_sent = 0;
		mismatches = 0;
		cycle_count = 0;
		hold_left = 0;
		hold_req = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 77;
		reset_parser();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) push_byte(dir_rows[i].stim, dir_rows[i].kind, dir_rows[i].word);
		settle();

		for (int s = 0; s < 6; s++) begin
			send_idle_pct = (s < 2) ? 33 : (s < 4) ? 77 : 0;
			recv_idle_pct = (s < 2) ? 77 : (s < 4) ? 33 : 0;
			write_reg(tsni_pkg::REG_VERSION_MIN, win_lo_set[s]);
			write_reg(tsni_pkg::REG_VERSION_MAX, win_hi_set[s]);
			cfg_ch.valid <= 1'b0;
			// long result back-pressure so the input side stalls
			if (s == 0) hold_req = 1'b1;
			seg_end = items_sent + SEG_ITEMS;
			while (items_sent < seg_end) send_random_payload();
			settle();
		end

		if (mismatches == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end
endmodule
